@@ rtl/rmi_pkg.sv @@
// Package for the RNS modular inverse block.
// Holds the transaction type passed from front to back, the result type and sizes.
package rmi_pkg;
    localparam int REG_BITS  = 61;
    localparam int NUM_REGS  = 6;
    localparam int VAL_BITS  = 64;
    localparam int LIMB_BITS = 3;

    typedef struct packed {
        logic [VAL_BITS-1:0] value;
        logic [REG_BITS-1:0] modulus;
        logic                active;
        logic [LIMB_BITS-1:0] limb;
        logic                last;
    } job_t;

    typedef struct packed {
        logic [REG_BITS-1:0] inverse;
        logic                written;
        logic                all_ok;
        logic                done;
    } res_t;
endpackage

@@ rtl/rmi_front.sv @@
// Front end: accepts coefficient transactions, selects the limb modulus.
// Depends on rmi_pkg.
module rmi_front #(
    parameter int LIMBS    = 6,
    parameter int MOD_BITS = 61
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rmi_pkg::REG_BITS*rmi_pkg::NUM_REGS-1:0] mods,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rmi_pkg::VAL_BITS-1:0]      value,
    input  logic [rmi_pkg::LIMB_BITS-1:0]     limb,
    input  logic                              last,
    output logic                              q_valid,
    input  logic                              q_stall,
    output rmi_pkg::job_t                     q_job
);
    rmi_pkg::job_t job_reg;
    logic          full_reg;
    logic [rmi_pkg::REG_BITS-1:0] m;
    logic [63:0] mmask;

    assign mmask = (MOD_BITS >= 64) ? '1 : ((64'd1 << MOD_BITS) - 64'd1);
    assign in_stall = full_reg && q_stall;
    assign q_valid  = full_reg;
    assign q_job    = job_reg;

    always_comb
    begin
        m = '0;
        if (limb < rmi_pkg::LIMB_BITS'(rmi_pkg::NUM_REGS))
            m = mods[limb*rmi_pkg::REG_BITS +: rmi_pkg::REG_BITS];
        m = m & mmask[rmi_pkg::REG_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (!in_stall)
            full_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            job_reg.value   <= value;
            job_reg.modulus <= m;
            job_reg.limb    <= limb;
            job_reg.last    <= last;
            job_reg.active  <= (32'(limb) < LIMBS);
        end
    end
endmodule

@@ rtl/rmi_back.sv @@
// Back end: reduction by restoring division, then binary extended Euclid.
// Keeps the per-limb failure flags. Depends on rmi_pkg.
module rmi_back #(
    parameter int LIMBS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_stall,
    input  rmi_pkg::job_t q_job,
    output logic          out_valid,
    input  logic          out_stall,
    output rmi_pkg::res_t res
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RED = 3'd1, S_EUC = 3'd2,
                           S_FIN = 3'd3, S_OUT = 3'd4;
    localparam int W = rmi_pkg::REG_BITS;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  cnt_reg;
    logic [63:0] val_reg;
    logic [W:0]  rem_reg;
    logic [W-1:0] m_reg, a_reg, u_reg, v_reg, x1_reg, x2_reg;
    logic signed [W+1:0] k1_reg, k2_reg;
    logic [LIMBS-1:0] fail_reg, fail_sh;
    logic [rmi_pkg::LIMB_BITS-1:0] limb_reg;
    logic        last_reg, act_reg;
    rmi_pkg::res_t res_reg, out_reg;
    logic        ovalid_reg;

    logic [W:0]   rsh, rsub;
    logic [W:0]   hx1, hx2, d1, d2;
    logic [W-1:0] nx1, nx2;
    logic signed [W+1:0] ka, hk1, hk2, nk1, nk2;
    logic         odd1, odd2, ok, stop, elig, runs;

    assign q_stall   = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign res       = out_reg;
    assign fail_sh   = fail_reg >> q_job.limb;
    // elig: limb in range and not yet failed; runs: also a usable modulus
    assign elig      = q_job.active && !fail_sh[0];
    assign runs      = elig && (q_job.modulus >= W'(2));

    // u = x1*a + k1*m and v = x2*a + k2*m hold exactly; k keeps halving
    // valid for even moduli too
    always_comb
    begin
        rsh  = {rem_reg[W-1:0], val_reg[63]};
        rsub = rsh - {1'b0, m_reg};
        ka   = {2'b00, a_reg};
        odd1 = x1_reg[0] || k1_reg[0];
        odd2 = x2_reg[0] || k2_reg[0];
        hx1 = odd1 ? ({1'b0, x1_reg} + {1'b0, m_reg}) : {1'b0, x1_reg};
        hx2 = odd2 ? ({1'b0, x2_reg} + {1'b0, m_reg}) : {1'b0, x2_reg};
        hk1 = odd1 ? (k1_reg - ka) : k1_reg;
        hk2 = odd2 ? (k2_reg - ka) : k2_reg;
        d1  = {1'b0, x1_reg} - {1'b0, x2_reg};
        nx1 = d1[W] ? W'(d1 + {1'b0, m_reg}) : d1[W-1:0];
        nk1 = d1[W] ? (k1_reg - k2_reg - ka) : (k1_reg - k2_reg);
        d2  = {1'b0, x2_reg} - {1'b0, x1_reg};
        nx2 = d2[W] ? W'(d2 + {1'b0, m_reg}) : d2[W-1:0];
        nk2 = d2[W] ? (k2_reg - k1_reg - ka) : (k2_reg - k1_reg);
        ok  = (u_reg == W'(1)) || (v_reg == W'(1));
        // both even only at the start: common factor two, no inverse
        stop = ok || (u_reg == '0) || (v_reg == '0) || (!u_reg[0] && !v_reg[0]);
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid) state_next = runs ? S_RED : S_FIN;
            S_RED:  if (cnt_reg == 7'd63) state_next = S_EUC;
            S_EUC:  if (stop) state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:  if (!ovalid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fail_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (state_reg == S_OUT && state_next == S_IDLE)
            begin
                ovalid_reg <= 1'b1;
                if (last_reg)
                    fail_reg <= '0;
                else if (act_reg && !res_reg.written)
                    fail_reg <= fail_reg | (LIMBS'(1) << limb_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                val_reg  <= q_job.value;
                m_reg    <= q_job.modulus;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                limb_reg <= q_job.limb;
                last_reg <= q_job.last;
                act_reg  <= elig;
                res_reg.written <= 1'b0;
            end
            S_RED:
            begin
                val_reg <= {val_reg[62:0], 1'b0};
                rem_reg <= rsub[W] ? rsh : rsub;
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    u_reg  <= rsub[W] ? rsh[W-1:0] : rsub[W-1:0];
                    a_reg  <= rsub[W] ? rsh[W-1:0] : rsub[W-1:0];
                    v_reg  <= m_reg;
                    x1_reg <= W'(1);
                    x2_reg <= '0;
                    k1_reg <= '0;
                    k2_reg <= {{(W+1){1'b0}}, 1'b1};
                end
            end
            S_EUC:
            begin
                if (state_next == S_EUC)
                begin
                    if (!u_reg[0])
                    begin
                        u_reg  <= u_reg >> 1;
                        x1_reg <= hx1[W:1];
                        k1_reg <= hk1 >>> 1;
                    end
                    else if (!v_reg[0])
                    begin
                        v_reg  <= v_reg >> 1;
                        x2_reg <= hx2[W:1];
                        k2_reg <= hk2 >>> 1;
                    end
                    else if (u_reg >= v_reg)
                    begin
                        u_reg  <= u_reg - v_reg;
                        x1_reg <= nx1;
                        k1_reg <= nk1;
                    end
                    else
                    begin
                        v_reg  <= v_reg - u_reg;
                        x2_reg <= nx2;
                        k2_reg <= nk2;
                    end
                end
                else
                begin
                    res_reg.written <= ok;
                    res_reg.inverse <= (u_reg == W'(1)) ? x1_reg : x2_reg;
                end
            end
            S_FIN:
            begin
                if (!res_reg.written)
                    res_reg.inverse <= '0;
                res_reg.done   <= last_reg;
                res_reg.all_ok <= last_reg && (fail_reg == '0)
                                  && !(act_reg && !res_reg.written);
            end
            S_OUT:
            begin
                // output register frees the work register for the next item
                if (state_next == S_IDLE)
                    out_reg <= res_reg;
            end
            default: ;
        endcase
    end
endmodule

@@ rtl/rns_modular_inverse.sv @@
// Top level of the RNS modular inverse block.
// Depends on rmi_pkg, rmi_front and rmi_back.
//
// Each coefficient transaction is reduced modulo its limb's modulus by a
// 64-step restoring division and inverted by binary extended Euclid, one
// step per cycle. Even and composite moduli are handled. A one-entry front
// register accepts the next item while the back end works, and an output
// register holds the finished transaction while the next one is computed.
// Failed limbs skip the work. Moduli are written through the config port.
module rns_modular_inverse #(
    parameter int LIMBS    = 6,
    parameter int MOD_BITS = 61
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [60:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] coeff_value,
    input  logic [2:0]  limb_index,
    input  logic        poly_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [60:0] inverse_value,
    output logic        written,
    output logic        all_invertible,
    output logic        poly_done
);
    logic [rmi_pkg::REG_BITS*rmi_pkg::NUM_REGS-1:0] mods_reg;
    logic          q_valid, q_stall;
    rmi_pkg::job_t q_job;
    rmi_pkg::res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mods_reg <= {rmi_pkg::NUM_REGS{61'd2}};
        else if (cfg_valid && cfg_index < 3'(rmi_pkg::NUM_REGS))
            mods_reg[cfg_index*rmi_pkg::REG_BITS +: rmi_pkg::REG_BITS] <= cfg_data;
    end

    rmi_front #(.LIMBS(LIMBS), .MOD_BITS(MOD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .mods(mods_reg),
        .in_valid(in_valid), .in_stall(in_stall), .value(coeff_value),
        .limb(limb_index), .last(poly_last),
        .q_valid(q_valid), .q_stall(q_stall), .q_job(q_job)
    );

    rmi_back #(.LIMBS(LIMBS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_stall(q_stall),
        .q_job(q_job), .out_valid(out_valid), .out_stall(out_stall), .res(res)
    );

    assign inverse_value  = res.inverse;
    assign written        = res.written;
    assign all_invertible = res.all_ok;
    assign poly_done      = res.done;
endmodule
